>>> hw/rtl/bed_pkg.sv
// Package for the button event detector: event, mode and register codes,
// field widths and the event set passed from evaluation to the result buffer.
// No dependencies.
package bed_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned MODE_W = 2;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd500;
  localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd200;
  localparam logic [CFG_W-1:0] DOUBLE_WIN_RST = 16'd200;

  typedef enum logic [EV_W-1:0] {
    EV_PRESS   = 3'd0,
    EV_CHANGE  = 3'd1,
    EV_LONG    = 3'd2,
    EV_REPEAT  = 3'd3,
    EV_CLICK   = 3'd4,
    EV_RELEASE = 3'd5,
    EV_DOUBLE  = 3'd6
  } ev_code_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_RELEASED = 2'd0,
    MODE_PRESSED  = 2'd1,
    MODE_LONG     = 2'd2
  } mode_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_ENABLE     = 3'd0,
    CFG_IDLE_LEVEL = 3'd1,
    CFG_LONG_PRESS = 3'd2,
    CFG_REPEAT     = 3'd3,
    CFG_DOUBLE_WIN = 3'd4
  } cfg_idx_e;

  // Events caused by one scan, oldest in ev0.
  typedef struct packed {
    logic [1:0] num;
    ev_code_e   ev0;
    ev_code_e   ev1;
    ev_code_e   ev2;
    mode_e      mode;
  } ev_set_t;

endpackage

>>> hw/rtl/bed_if.sv
// Valid/ready channel interfaces for scans in and events out.
// Depends on bed_pkg.
interface bed_scan_if import bed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pin_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, pin_level, now_ms, input ready);
  modport sink   (input valid, pin_level, now_ms, output ready);
endinterface

interface bed_event_if import bed_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [EV_W-1:0]   event_code;
  logic [MODE_W-1:0] button_mode;
  logic              last_event;

  modport source (output valid, event_code, button_mode, last_event, input ready);
  modport sink   (input valid, event_code, button_mode, last_event, output ready);
endinterface

>>> hw/rtl/bed_eval.sv
// Scan register, configuration registers, button state and event evaluation.
// Depends on bed_pkg.
module bed_eval import bed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              scan_valid_i,
  output logic              scan_ready_o,
  input  logic              pin_level_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic              load_ok_i,
  output logic              load_o,
  output ev_set_t           set_o
);

  logic              enable_q, idle_q;
  logic [CFG_W-1:0]  long_ms_q, rep_ms_q, win_ms_q;
  logic              in_vld_q, pin_q;
  logic [TIME_W-1:0] now_q;
  logic              pressed_q, long_q;
  logic [TIME_W-1:0] press_t_q, long_t_q, rel_t_q;
  mode_e             mode_q;

  logic              fire, upd, active, held_long;
  logic [TIME_W-1:0] dp, dl, dr;
  ev_set_t           set;
  logic              pressed_d, long_d;
  logic [TIME_W-1:0] press_t_d, long_t_d, rel_t_d;

  assign fire         = in_vld_q && load_ok_i;
  assign upd          = fire && enable_q;
  assign scan_ready_o = !in_vld_q || load_ok_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      idle_q    <= 1'b0;
      long_ms_q <= LONG_PRESS_RST;
      rep_ms_q  <= REPEAT_RST;
      win_ms_q  <= DOUBLE_WIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENABLE:     enable_q  <= cfg_data_i[0];
        CFG_IDLE_LEVEL: idle_q    <= cfg_data_i[0];
        CFG_LONG_PRESS: long_ms_q <= cfg_data_i;
        CFG_REPEAT:     rep_ms_q  <= cfg_data_i;
        CFG_DOUBLE_WIN: win_ms_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (scan_ready_o) begin
      in_vld_q <= scan_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_ready_o && scan_valid_i) begin
      pin_q <= pin_level_i;
      now_q <= now_ms_i;
    end
  end

  assign active    = pin_q != idle_q;
  assign dp        = now_q - press_t_q;
  assign dl        = now_q - long_t_q;
  assign dr        = now_q - rel_t_q;
  assign held_long = dp >= {{(TIME_W-CFG_W){1'b0}}, long_ms_q};

  always_comb begin
    set       = '{num: 2'd0, ev0: EV_PRESS, ev1: EV_PRESS, ev2: EV_PRESS, mode: mode_q};
    pressed_d = pressed_q;
    long_d    = long_q;
    press_t_d = press_t_q;
    long_t_d  = long_t_q;
    rel_t_d   = rel_t_q;
    priority if (!pressed_q && active) begin
      pressed_d = 1'b1;
      press_t_d = now_q;
      set.mode  = MODE_PRESSED;
      set.ev0   = EV_PRESS;
      set.ev1   = EV_CHANGE;
      set.ev2   = EV_DOUBLE;
      set.num   = (dr < {{(TIME_W-CFG_W){1'b0}}, win_ms_q}) ? 2'd3 : 2'd2;
    end else if (pressed_q && active && held_long) begin
      set.mode = MODE_LONG;
      if (!long_q) begin
        long_d   = 1'b1;
        long_t_d = now_q;
        set.ev0  = EV_LONG;
        set.num  = 2'd1;
      end else if (dl >= {{(TIME_W-CFG_W){1'b0}}, rep_ms_q}) begin
        long_t_d = now_q;
        set.ev0  = EV_REPEAT;
        set.num  = 2'd1;
      end
    end else if (pressed_q && !active) begin
      pressed_d = 1'b0;
      long_d    = 1'b0;
      rel_t_d   = now_q;
      set.mode  = MODE_RELEASED;
      if (!held_long) begin
        set.ev0 = EV_CLICK;
        set.ev1 = EV_RELEASE;
        set.ev2 = EV_CHANGE;
        set.num = 2'd3;
      end else begin
        set.ev0 = EV_RELEASE;
        set.ev1 = EV_CHANGE;
        set.num = 2'd2;
      end
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q <= 1'b0;
      long_q    <= 1'b0;
      press_t_q <= '0;
      long_t_q  <= '0;
      rel_t_q   <= '0;
      mode_q    <= MODE_RELEASED;
    end else if (upd) begin
      pressed_q <= pressed_d;
      long_q    <= long_d;
      press_t_q <= press_t_d;
      long_t_q  <= long_t_d;
      rel_t_q   <= rel_t_d;
      mode_q    <= set.mode;
    end
  end

  assign load_o = upd && (set.num != 2'd0);
  assign set_o  = set;

endmodule

>>> hw/rtl/bed_emit.sv
// Result buffer: holds the events of one scan and hands them out one a cycle
// while the output is ready. Depends on bed_pkg.
module bed_emit import bed_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ev_set_t           set_i,
  output logic              load_ok_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [EV_W-1:0]   event_code_o,
  output logic [MODE_W-1:0] button_mode_o,
  output logic              last_event_o
);

  logic [1:0] cnt_q, cnt_d;
  ev_code_e   ev0_q, ev1_q, ev2_q;
  mode_e      mode_q;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign load_ok_o   = (cnt_q == 2'd0) || (pop && cnt_q == 2'd1);

  always_comb begin
    cnt_d = cnt_q;
    priority if (load_i) begin
      cnt_d = set_i.num;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      ev0_q  <= set_i.ev0;
      ev1_q  <= set_i.ev1;
      ev2_q  <= set_i.ev2;
      mode_q <= set_i.mode;
    end else if (pop) begin
      ev0_q <= ev1_q;
      ev1_q <= ev2_q;
    end
  end

  assign event_code_o  = ev0_q;
  assign button_mode_o = mode_q;
  assign last_event_o  = cnt_q == 2'd1;

endmodule

>>> hw/rtl/button_event_detector.sv
// Top level of the button event detector: scan register and evaluation,
// result buffer. Depends on bed_pkg, bed_if, bed_eval and bed_emit.
//
// Each scan is registered, then evaluated against the button state once the
// result buffer can take its events. Its events (none to three) are loaded
// into a three-entry result buffer that shows them one per cycle while the
// output is ready. A scan passes the scan register and then the result buffer
// before its first event is on the output. A scan is evaluated only when the
// buffer is empty or its final event is being taken, so while events drain
// the next scan waits in the scan register. Scans causing no event, and all
// scans while enable is low, pass one per cycle while the buffer is empty.
// A stalled output holds the buffer, and through it the scan input.
module button_event_detector import bed_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  bed_scan_if.sink         scan_i,
  bed_event_if.source      evt_o
);

  logic    load, load_ok;
  ev_set_t set;

  bed_eval u_eval (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .scan_valid_i (scan_i.valid),
    .scan_ready_o (scan_i.ready),
    .pin_level_i  (scan_i.pin_level),
    .now_ms_i     (scan_i.now_ms),
    .load_ok_i    (load_ok),
    .load_o       (load),
    .set_o        (set)
  );

  bed_emit u_emit (
    .clk_i,
    .rst_ni,
    .load_i        (load),
    .set_i         (set),
    .load_ok_o     (load_ok),
    .out_valid_o   (evt_o.valid),
    .out_ready_i   (evt_o.ready),
    .event_code_o  (evt_o.event_code),
    .button_mode_o (evt_o.button_mode),
    .last_event_o  (evt_o.last_event)
  );

endmodule

>>> hw/rtl/bed_checker.sv
// Port-level checks for the button event detector, bound to the top level.
// Depends on bed_pkg and button_event_detector.
module bed_checker import bed_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid,
  input logic              out_ready,
  input logic [EV_W-1:0]   event_code,
  input logic [MODE_W-1:0] button_mode,
  input logic              last_event
);

  logic take;
  assign take = out_valid && out_ready;

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(event_code) && $stable(last_event))
    else $error("stalled item changed");

  a_mode_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !last_event |=> out_valid && button_mode == $past(button_mode))
    else $error("mode changed within one scan");

  a_press_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && event_code == EV_PRESS |=> out_valid && event_code == EV_CHANGE)
    else $error("press not followed by change");

  a_release_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && event_code == EV_RELEASE |=> out_valid && event_code == EV_CHANGE && last_event)
    else $error("release not followed by final change");

  a_press_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && event_code == EV_PRESS |-> button_mode == MODE_PRESSED && !last_event)
    else $error("press with wrong mode");

endmodule

bind button_event_detector bed_checker u_bed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (evt_o.valid),
  .out_ready   (evt_o.ready),
  .event_code  (evt_o.event_code),
  .button_mode (evt_o.button_mode),
  .last_event  (evt_o.last_event)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for button_event_detector: directed and random scans,
// events predicted in the bench and compared item by item on the event channel.
// Depends on bed_pkg, bed_if and the detector RTL.
module tb_top;
  import bed_pkg::*;

  typedef struct packed {
    logic              pin;
    logic [TIME_W-1:0] stamp;
  } scan_t;

  typedef struct {
    ev_code_e code;
    mode_e    btn_mode;
    logic     last_ev;
  } bed_event_t;

  logic clk = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  bed_scan_if  scan_if ();
  bed_event_if evt_if ();

  button_event_detector dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .scan_i     (scan_if),
    .evt_o      (evt_if)
  );

  // Shadow configuration
  logic             cfg_enable     = 1'b0;
  logic             cfg_idle       = 1'b0;
  logic [CFG_W-1:0] cfg_long       = LONG_PRESS_RST;
  logic [CFG_W-1:0] cfg_repeat     = REPEAT_RST;
  logic [CFG_W-1:0] cfg_double_win = DOUBLE_WIN_RST;

  // Predicted button state
  logic              btn_held  = 1'b0;
  logic              long_held = 1'b0;
  logic [TIME_W-1:0] t_press   = '0;
  logic [TIME_W-1:0] t_long    = '0;
  logic [TIME_W-1:0] t_release = '0;
  mode_e             btn_mode  = MODE_RELEASED;

  scan_t      pending_scans[$];
  bed_event_t expected_events[$];
  bed_event_t want;
  scan_t      next_scan;

  logic              scan_taken = 1'b0;
  int unsigned       scan_gap   = 0;
  int unsigned       ready_gap  = 0;
  bit                gaps_on    = 1'b1;
  int unsigned       mismatches = 0;
  logic [TIME_W-1:0] scan_clock = '0;

  always #2 clk = ~clk;

  function automatic void predict_scan(logic pin, logic [TIME_W-1:0] now);
    ev_code_e          evs[$];
    logic              active;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_release;
    logic [TIME_W-1:0] since_long;
    if (!cfg_enable) return;
    active        = (pin != cfg_idle);
    since_press   = now - t_press;
    since_release = now - t_release;
    since_long    = now - t_long;
    if (!btn_held && active) begin
      btn_held = 1'b1;
      btn_mode = MODE_PRESSED;
      t_press  = now;
      evs.push_back(EV_PRESS);
      evs.push_back(EV_CHANGE);
      if (since_release < TIME_W'(cfg_double_win)) evs.push_back(EV_DOUBLE);
    end else if (btn_held && active && since_press >= TIME_W'(cfg_long)) begin
      btn_mode = MODE_LONG;
      if (!long_held) begin
        long_held = 1'b1;
        t_long    = now;
        evs.push_back(EV_LONG);
      end else if (since_long >= TIME_W'(cfg_repeat)) begin
        t_long = now;
        evs.push_back(EV_REPEAT);
      end
    end else if (btn_held && !active) begin
      btn_held  = 1'b0;
      long_held = 1'b0;
      btn_mode  = MODE_RELEASED;
      t_release = now;
      if (since_press < TIME_W'(cfg_long)) evs.push_back(EV_CLICK);
      evs.push_back(EV_RELEASE);
      evs.push_back(EV_CHANGE);
    end
    for (int k = 0; k < evs.size(); k++)
      expected_events.push_back('{evs[k], btn_mode, (k == evs.size() - 1)});
  endfunction

  function automatic void add_scan(logic pin, logic [TIME_W-1:0] stamp);
    pending_scans.push_back('{pin, stamp});
  endfunction

  // Press held over one to ten scans, then one to three released scans.
  function automatic int unsigned add_gesture();
    int unsigned hold_scans;
    int unsigned rest_scans;
    int unsigned hold_step;
    int unsigned rest_step;
    hold_scans = $urandom_range(1, 10);
    rest_scans = $urandom_range(1, 3);
    hold_step  = cfg_long / 4 + 8;
    rest_step  = cfg_double_win / 2 + 8;
    for (int i = 0; i < hold_scans; i++) begin
      scan_clock += $urandom_range(0, hold_step);
      add_scan(~cfg_idle, scan_clock);
    end
    for (int i = 0; i < rest_scans; i++) begin
      scan_clock += $urandom_range(1, rest_step);
      add_scan(cfg_idle, scan_clock);
    end
    return hold_scans + rest_scans;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ENABLE:     cfg_enable     = value[0];
      CFG_IDLE_LEVEL: cfg_idle       = value[0];
      CFG_LONG_PRESS: cfg_long       = value;
      CFG_REPEAT:     cfg_repeat     = value;
      CFG_DOUBLE_WIN: cfg_double_win = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic en, logic idle, logic [CFG_W-1:0] long_ms,
                            logic [CFG_W-1:0] rep_ms, logic [CFG_W-1:0] win_ms);
    write_reg(CFG_IDLE_LEVEL, {{(CFG_W-1){1'b0}}, idle});
    write_reg(CFG_LONG_PRESS, long_ms);
    write_reg(CFG_REPEAT, rep_ms);
    write_reg(CFG_DOUBLE_WIN, win_ms);
    write_reg(CFG_ENABLE, {{(CFG_W-1){1'b0}}, en});
  endtask

  // Hold until every scan is taken and every event has come out.
  task automatic settle();
    while (pending_scans.size() != 0 || scan_if.valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!scan_if.valid || scan_taken) begin
      if (scan_gap != 0) begin
        scan_gap <= scan_gap - 1;
        scan_if.valid <= 1'b0;
      end else if (pending_scans.size() != 0) begin
        if (gaps_on && $urandom_range(0, 4) == 0) begin
          scan_gap <= $urandom_range(1, 7) - 1;
          scan_if.valid <= 1'b0;
        end else begin
          next_scan = pending_scans.pop_front();
          scan_if.pin_level <= next_scan.pin;
          scan_if.now_ms    <= next_scan.stamp;
          scan_if.valid     <= 1'b1;
        end
      end else begin
        scan_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (ready_gap != 0) begin
      ready_gap <= ready_gap - 1;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      ready_gap <= $urandom_range(1, 7) - 1;
      evt_if.ready <= 1'b0;
    end else begin
      evt_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    scan_taken <= scan_if.valid && scan_if.ready;
    if (rst_ni) begin
      if (evt_if.valid && evt_if.ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event: expected none, got code %0d mode %0d last %0d",
                   $time, evt_if.event_code, evt_if.button_mode, evt_if.last_event);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (evt_if.event_code !== want.code || evt_if.button_mode !== want.btn_mode ||
              evt_if.last_event !== want.last_ev) begin
            $display({"%0t: event mismatch: expected code %0d mode %0d last %0d,",
                      " got code %0d mode %0d last %0d"},
                     $time, want.code, want.btn_mode, want.last_ev,
                     evt_if.event_code, evt_if.button_mode, evt_if.last_event);
            mismatches++;
          end
        end
      end
      if (scan_if.valid && scan_if.ready)
        predict_scan(scan_if.pin_level, scan_if.now_ms);
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    int unsigned queued;
    bit          interlude_done;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_ENABLE;
    cfg_data          = '0;
    scan_if.valid     = 1'b0;
    scan_if.pin_level = 1'b0;
    scan_if.now_ms    = '0;
    evt_if.ready      = 1'b0;
    interlude_done    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // Disabled after reset: scans are dropped
    add_scan(1'b1, 32'h0000_0000);
    add_scan(1'b0, 32'hFFFF_FFFF);
    settle();
    set_config(1'b1, 1'b0, 16'd500, 16'd200, 16'd200);
    add_scan(1'b1, 32'd50);
    add_scan(1'b1, 32'd300);
    add_scan(1'b1, 32'd550);
    add_scan(1'b1, 32'd700);
    add_scan(1'b1, 32'd750);
    add_scan(1'b0, 32'd800);
    add_scan(1'b1, 32'd900);
    add_scan(1'b0, 32'd950);
    add_scan(1'b1, 32'd1150);
    add_scan(1'b0, 32'd1200);
    // Across the timestamp wrap
    add_scan(1'b0, 32'hFFFF_FF00);
    add_scan(1'b1, 32'hFFFF_FF80);
    add_scan(1'b1, 32'h0000_0100);
    add_scan(1'b1, 32'h0000_0174);
    add_scan(1'b0, 32'h0000_0200);
    settle();
    // Zero hold and repeat times, widest double-click window, inverted pin
    set_config(1'b1, 1'b1, 16'd0, 16'd0, 16'hFFFF);
    add_scan(1'b0, 32'd10);
    add_scan(1'b0, 32'd10);
    add_scan(1'b0, 32'd10);
    add_scan(1'b1, 32'd20);
    add_scan(1'b0, 32'd30);
    add_scan(1'b1, 32'd30);

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      gaps_on = (phase < 5);
      case (phase)
        0: set_config(1'b1, 1'b0, 16'd100, 16'd40, 16'd150);
        1: set_config(1'b1, 1'b1, 16'd0, 16'd0, 16'hFFFF);
        2: set_config(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'd0);
        default: set_config(1'b1, 1'($urandom_range(0, 1)),
                            CFG_W'($urandom_range(0, 400)),
                            CFG_W'($urandom_range(0, 200)),
                            CFG_W'($urandom_range(0, 400)));
      endcase
      scan_clock = (phase == 1) ? 32'hFFFF_FF00 : $urandom();
      queued = 0;
      while (queued < 22) begin
        if ($urandom_range(0, 7) == 0) begin
          add_scan(1'($urandom_range(0, 1)), $urandom());
          queued++;
        end else begin
          queued += add_gesture();
        end
        if (phase == 3 && queued >= 11 && !interlude_done) begin
          interlude_done = 1'b1;
          settle();
          write_reg(CFG_ENABLE, '0);
          void'(add_gesture());
          settle();
          write_reg(CFG_ENABLE, 16'd1);
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/bed_pkg.sv
hw/rtl/bed_if.sv
hw/rtl/bed_eval.sv
hw/rtl/bed_emit.sv
hw/rtl/button_event_detector.sv
hw/rtl/bed_checker.sv
tb/tb_top.sv
